[hdl/atfp_pkg.sv]
// shared types, byte codes and helpers for the ascii tuning frame parser
// used by atfp_value and ascii_tuning_frame_parser; depends on nothing
`default_nettype none

package atfp_pkg;

   // default configuration handed to the top level parameters
   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_FRAC_DIGITS = 8;
   localparam int DEF_MAX_PAYLOAD = 64;

   // value widths
   localparam int VAL_W  = 48;
   localparam int WIDE_W = 53;

   // reciprocal divider widths: dividend, multiplier, product, shift amount
   localparam int DIV_N_W = 32;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = DIV_N_W + MUL_W;
   localparam int SH_W    = 6;

   localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;

   // ascii codes used by the frame matchers
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // powers of ten for the fraction digit positions
   localparam longint unsigned POW10 [10] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000
   };

   typedef enum logic [2:0] {
      PP_HASH, PP_LETTER, PP_LOOP, PP_UNDER, PP_COEF, PP_EQUAL, PP_PAYLOAD
   } param_phase_type;

   typedef enum logic [2:0] {
      SP_AT, SP_F, SP_L, SP_A, SP_G, SP_EQUAL, SP_PAYLOAD
   } switch_phase_type;

   // control from the frame matcher to the value accumulator
   typedef struct packed {
      logic clear;
      logic take;
   } value_ctrl_type;

   // clamp a wide intermediate to the symmetric value range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(VAL_MAX);
      lo = -hi;
      if (v > hi) begin
         return VAL_MAX;
      end else if (v < lo) begin
         return -VAL_MAX;
      end
      return $signed(v[VAL_W-1:0]);
   endfunction

endpackage

`default_nettype wire

[hdl/ascii_tuning_frame_parser.sv]
// top level of the ascii tuning frame parser: byte skid register, both frame
// matchers and the result register; depends on atfp_pkg and atfp_value
//
// Usage:
//   req channel carries one received byte per transaction (req_rx_byte).
//   rsp channel carries one result whenever a parameter frame "#Pa_b=...!"
//   or a switch frame "@Flag=c!" ends on a byte; both flags are set when one
//   '!' closes both. Bytes that close no frame produce no transaction.
//   Timing: a taken byte is held in the input register and matched there;
//   its result is loaded into the result register when that byte is consumed.
//   Throughput: one byte per cycle while no closing byte waits on rsp_ready.
//   The figure is set by the accumulator loop: the reciprocal multiply for
//   the fraction digit and the saturating add feed the value register.
//   Stall: while a result waits on rsp_ready, bytes that close no frame keep
//   flowing; a byte that would close a frame waits in the input register and
//   req_ready drops once that register is full.
//   Reset: synchronous, clears both matchers, the payload state, the stored
//   switch code and both registers' valid flags.
`default_nettype none

module ascii_tuning_frame_parser #(
   parameter int FRAC_BITS   = atfp_pkg::DEF_FRAC_BITS,
   parameter int FRAC_DIGITS = atfp_pkg::DEF_FRAC_DIGITS,
   parameter int MAX_PAYLOAD = atfp_pkg::DEF_MAX_PAYLOAD
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_rx_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_param_done,
   output logic [7:0]                          rsp_loop_select,
   output logic [7:0]                          rsp_coef_select,
   output logic signed [atfp_pkg::VAL_W-1:0]   rsp_param_value,
   output logic                                rsp_payload_overflow,
   output logic                                rsp_switch_done,
   output logic [7:0]                          rsp_switch_code
);

   // input skid register
   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       req_accept;
   logic       consume;
   logic       fire;

   // matcher state
   atfp_pkg::param_phase_type  param_phase_ff, param_phase_in;
   atfp_pkg::switch_phase_type switch_phase_ff, switch_phase_in;
   logic [7:0] loop_id_ff, loop_id_in;
   logic [7:0] coef_id_ff, coef_id_in;
   logic       switch_seen_ff, switch_seen_in;
   logic [7:0] switch_value_ff, switch_value_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              pdone_ff, pdone_in;
   logic [7:0]                        lsel_ff, lsel_in;
   logic [7:0]                        csel_ff, csel_in;
   logic signed [atfp_pkg::VAL_W-1:0] pval_ff, pval_in;
   logic                              povf_ff, povf_in;
   logic                              sdone_ff, sdone_in;
   logic [7:0]                        scode_ff, scode_in;

   // decoded matcher outputs
   logic capture_loop, capture_coef, param_clear, param_take, pdone;
   logic switch_clear, switch_take, sdone;
   atfp_pkg::value_ctrl_type          value_ctrl;
   logic signed [atfp_pkg::VAL_W-1:0] value;
   logic                              overflow;

   // handshake: a closing byte waits while the result register is occupied
   assign fire       = pdone || sdone;
   assign consume    = byte_valid_ff && (!fire || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !byte_valid_ff || consume;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      if (req_accept) begin
         byte_valid_in = 1'b1;
         byte_in       = req_rx_byte;
      end else if (consume) begin
         byte_valid_in = 1'b0;
      end
   end

   // parameter matcher next state
   always_comb begin
      param_phase_in = param_phase_ff;
      case (param_phase_ff)
         atfp_pkg::PP_HASH: begin
            if (byte_ff == atfp_pkg::CH_HASH) param_phase_in = atfp_pkg::PP_LETTER;
         end
         atfp_pkg::PP_LETTER: begin
            if (byte_ff == atfp_pkg::CH_P) param_phase_in = atfp_pkg::PP_LOOP;
         end
         atfp_pkg::PP_LOOP:  param_phase_in = atfp_pkg::PP_UNDER;
         atfp_pkg::PP_UNDER: begin
            if (byte_ff == atfp_pkg::CH_UNDER) param_phase_in = atfp_pkg::PP_COEF;
         end
         atfp_pkg::PP_COEF:  param_phase_in = atfp_pkg::PP_EQUAL;
         atfp_pkg::PP_EQUAL: begin
            if (byte_ff == atfp_pkg::CH_EQUAL) param_phase_in = atfp_pkg::PP_PAYLOAD;
         end
         atfp_pkg::PP_PAYLOAD: begin
            if (byte_ff == atfp_pkg::CH_BANG) param_phase_in = atfp_pkg::PP_HASH;
         end
         default: param_phase_in = atfp_pkg::PP_HASH;
      endcase
   end

   // parameter matcher outputs
   always_comb begin
      capture_loop = 1'b0;
      capture_coef = 1'b0;
      param_clear  = 1'b0;
      param_take   = 1'b0;
      pdone        = 1'b0;
      case (param_phase_ff)
         atfp_pkg::PP_LOOP:  capture_loop = 1'b1;
         atfp_pkg::PP_COEF:  capture_coef = 1'b1;
         atfp_pkg::PP_EQUAL: param_clear  = (byte_ff == atfp_pkg::CH_EQUAL);
         atfp_pkg::PP_PAYLOAD: begin
            pdone       = (byte_ff == atfp_pkg::CH_BANG);
            param_clear = (byte_ff == atfp_pkg::CH_BANG);
            param_take  = (byte_ff != atfp_pkg::CH_BANG);
         end
         default: ;
      endcase
   end

   // switch matcher next state
   always_comb begin
      switch_phase_in = switch_phase_ff;
      case (switch_phase_ff)
         atfp_pkg::SP_AT: begin
            if (byte_ff == atfp_pkg::CH_AT) switch_phase_in = atfp_pkg::SP_F;
         end
         atfp_pkg::SP_F: begin
            if (byte_ff == atfp_pkg::CH_F) switch_phase_in = atfp_pkg::SP_L;
         end
         atfp_pkg::SP_L: begin
            if (byte_ff == atfp_pkg::CH_L) switch_phase_in = atfp_pkg::SP_A;
         end
         atfp_pkg::SP_A: begin
            if (byte_ff == atfp_pkg::CH_A) switch_phase_in = atfp_pkg::SP_G;
         end
         atfp_pkg::SP_G: begin
            if (byte_ff == atfp_pkg::CH_G) switch_phase_in = atfp_pkg::SP_EQUAL;
         end
         atfp_pkg::SP_EQUAL: begin
            if (byte_ff == atfp_pkg::CH_EQUAL) switch_phase_in = atfp_pkg::SP_PAYLOAD;
         end
         atfp_pkg::SP_PAYLOAD: begin
            if (byte_ff == atfp_pkg::CH_BANG) switch_phase_in = atfp_pkg::SP_AT;
         end
         default: switch_phase_in = atfp_pkg::SP_AT;
      endcase
   end

   // switch matcher outputs
   always_comb begin
      switch_clear = 1'b0;
      switch_take  = 1'b0;
      sdone        = 1'b0;
      case (switch_phase_ff)
         atfp_pkg::SP_EQUAL: switch_clear = (byte_ff == atfp_pkg::CH_EQUAL);
         atfp_pkg::SP_PAYLOAD: begin
            sdone        = (byte_ff == atfp_pkg::CH_BANG);
            switch_clear = (byte_ff == atfp_pkg::CH_BANG);
            switch_take  = (byte_ff != atfp_pkg::CH_BANG);
         end
         default: ;
      endcase
   end

   // id bytes and the first switch payload byte
   always_comb begin
      loop_id_in      = loop_id_ff;
      coef_id_in      = coef_id_ff;
      switch_seen_in  = switch_seen_ff;
      switch_value_in = switch_value_ff;
      if (consume) begin
         if (capture_loop) loop_id_in = byte_ff - atfp_pkg::CH_ZERO;
         if (capture_coef) coef_id_in = byte_ff - atfp_pkg::CH_ZERO;
         if (switch_clear) begin
            switch_seen_in = 1'b0;
         end else if (switch_take) begin
            switch_seen_in = 1'b1;
            if (!switch_seen_ff) switch_value_in = byte_ff - atfp_pkg::CH_ZERO;
         end
      end
   end

   // payload value accumulator
   assign value_ctrl.clear = consume && param_clear;
   assign value_ctrl.take  = consume && param_take;

   atfp_value #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_value (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (value_ctrl),
      .rx_byte  (byte_ff),
      .value    (value),
      .overflow (overflow)
   );

   // result register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pdone_in     = pdone_ff;
      lsel_in      = lsel_ff;
      csel_in      = csel_ff;
      pval_in      = pval_ff;
      povf_in      = povf_ff;
      sdone_in     = sdone_ff;
      scode_in     = scode_ff;
      if (consume && fire) begin
         rsp_valid_in = 1'b1;
         pdone_in     = pdone;
         lsel_in      = pdone ? loop_id_ff : 8'd0;
         csel_in      = pdone ? coef_id_ff : 8'd0;
         pval_in      = pdone ? value : '0;
         povf_in      = pdone && overflow;
         sdone_in     = sdone;
         scode_in     = sdone ? switch_value_ff : 8'd0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         param_phase_ff  <= atfp_pkg::PP_HASH;
         switch_phase_ff <= atfp_pkg::SP_AT;
         switch_seen_ff  <= 1'b0;
         switch_value_ff <= 8'd0;
         loop_id_ff      <= 8'd0;
         coef_id_ff      <= 8'd0;
      end else begin
         byte_valid_ff   <= byte_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         switch_seen_ff  <= switch_seen_in;
         switch_value_ff <= switch_value_in;
         loop_id_ff      <= loop_id_in;
         coef_id_ff      <= coef_id_in;
         if (consume) begin
            param_phase_ff  <= param_phase_in;
            switch_phase_ff <= switch_phase_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      pdone_ff <= pdone_in;
      lsel_ff  <= lsel_in;
      csel_ff  <= csel_in;
      pval_ff  <= pval_in;
      povf_ff  <= povf_in;
      sdone_ff <= sdone_in;
      scode_ff <= scode_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_param_done       = pdone_ff;
   assign rsp_loop_select      = lsel_ff;
   assign rsp_coef_select      = csel_ff;
   assign rsp_param_value      = pval_ff;
   assign rsp_payload_overflow = povf_ff;
   assign rsp_switch_done      = sdone_ff;
   assign rsp_switch_code      = scode_ff;

   // a result always carries at least one finished frame
   a_result_has_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_param_done || rsp_switch_done))
      else $error("result without a finished frame");

   // parameter fields are zero when no parameter frame ended
   a_param_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_param_done) |->
         (rsp_param_value == '0 && rsp_loop_select == 8'd0 &&
          rsp_coef_select == 8'd0 && !rsp_payload_overflow))
      else $error("parameter fields set without a parameter frame");

   // the saturated value never reaches the most negative code
   a_value_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_param_value != {1'b1, {(atfp_pkg::VAL_W-1){1'b0}}}))
      else $error("parameter value outside saturation range");

   // a closing byte is never processed over a pending result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (consume && fire) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

   // a stalled result holds its content into the next cycle
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_param_value) &&
                                     $stable(rsp_switch_code)))
      else $error("stalled result changed");

endmodule

`default_nettype wire

[hdl/atfp_value.sv]
// payload value accumulator: decimal text to signed fixed point with saturation
// depends on atfp_pkg; the fraction digit divide is a reciprocal multiply
`default_nettype none

module atfp_value #(
   parameter int FRAC_BITS   = atfp_pkg::DEF_FRAC_BITS,
   parameter int FRAC_DIGITS = atfp_pkg::DEF_FRAC_DIGITS,
   parameter int MAX_PAYLOAD = atfp_pkg::DEF_MAX_PAYLOAD
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire atfp_pkg::value_ctrl_type            ctrl,
   input  wire logic [7:0]                          rx_byte,
   output logic signed [atfp_pkg::VAL_W-1:0]        value,
   output logic                                     overflow
);

   localparam int FP_W  = $clog2(FRAC_DIGITS + 2);
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int FP_N  = FRAC_DIGITS + 2;

   logic signed [atfp_pkg::VAL_W-1:0] acc_ff, acc_in;
   logic                              neg_ff, neg_in;
   logic                              point_ff, point_in;
   logic [FP_W-1:0]                   frac_pos_ff, frac_pos_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              ovf_ff, ovf_in;

   // per position reciprocal constants
   logic [atfp_pkg::MUL_W-1:0]   mul_tab  [FP_N];
   logic [atfp_pkg::SH_W-1:0]    sh_tab   [FP_N];
   logic [atfp_pkg::DIV_N_W-1:0] half_tab [FP_N];

   for (genvar i = 0; i < FP_N; i++) begin : g_recip
      if (i >= 1 && i <= FRAC_DIGITS) begin : g_used
         localparam longint unsigned P   = atfp_pkg::POW10[i];
         localparam int              SH  = atfp_pkg::DIV_N_W + $clog2(P);
         localparam longint unsigned MUL = ((64'd1 << SH) + P - 64'd1) / P;
         assign mul_tab[i]  = atfp_pkg::MUL_W'(MUL);
         assign sh_tab[i]   = atfp_pkg::SH_W'(SH);
         assign half_tab[i] = atfp_pkg::DIV_N_W'(P / 64'd2);
      end else begin : g_unused
         assign mul_tab[i]  = '0;
         assign sh_tab[i]   = '0;
         assign half_tab[i] = '0;
      end
   end

   // digit value and its magnitude
   logic signed [8:0] digit;
   logic [7:0]        digit_mag;
   assign digit     = $signed({1'b0, rx_byte}) - $signed({1'b0, atfp_pkg::CH_ZERO});
   assign digit_mag = digit[8] ? 8'(-digit) : digit[7:0];

   // integer part: acc*10 saturated, then plus digit scaled
   logic signed [atfp_pkg::WIDE_W-1:0] acc_wide, times10, digit_unit, int_pre;
   logic signed [atfp_pkg::VAL_W-1:0]  times10_sat, int_sum;
   assign acc_wide    = atfp_pkg::WIDE_W'(acc_ff);
   assign times10     = (acc_wide <<< 3) + (acc_wide <<< 1);
   assign times10_sat = atfp_pkg::sat_val(times10);
   assign digit_unit  = atfp_pkg::WIDE_W'(digit) <<< FRAC_BITS;
   assign int_pre     = atfp_pkg::WIDE_W'(times10_sat) + digit_unit;
   assign int_sum     = atfp_pkg::sat_val(int_pre);

   // fraction digit: round(mag * 2^FRAC_BITS / 10^k), ties away from zero
   logic [atfp_pkg::DIV_N_W-1:0] dividend;
   logic [atfp_pkg::PROD_W-1:0]  product, quot_full;
   logic [atfp_pkg::DIV_N_W-1:0] quot;
   logic signed [atfp_pkg::WIDE_W-1:0] quot_wide, frac_pre;
   logic signed [atfp_pkg::VAL_W-1:0]  frac_sum;
   assign dividend  = (atfp_pkg::DIV_N_W'(digit_mag) << FRAC_BITS) + half_tab[frac_pos_ff];
   assign product   = atfp_pkg::PROD_W'(dividend) * atfp_pkg::PROD_W'(mul_tab[frac_pos_ff]);
   assign quot_full = product >> sh_tab[frac_pos_ff];
   assign quot      = quot_full[atfp_pkg::DIV_N_W-1:0];
   assign quot_wide = atfp_pkg::WIDE_W'($signed({1'b0, quot}));
   assign frac_pre  = digit[8] ? acc_wide - quot_wide : acc_wide + quot_wide;
   assign frac_sum  = atfp_pkg::sat_val(frac_pre);

   // next payload state
   always_comb begin
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      point_in    = point_ff;
      frac_pos_in = frac_pos_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      if (ctrl.clear) begin
         acc_in      = '0;
         neg_in      = 1'b0;
         point_in    = 1'b0;
         frac_pos_in = FP_W'(1);
         count_in    = '0;
         ovf_in      = 1'b0;
      end else if (ctrl.take) begin
         if (count_ff < CNT_W'(MAX_PAYLOAD)) begin
            count_in = count_ff + 1'b1;
            if (rx_byte == atfp_pkg::CH_MINUS) begin
               neg_in = 1'b1;
            end else if (!point_ff) begin
               if (rx_byte == atfp_pkg::CH_POINT) begin
                  point_in = 1'b1;
               end else begin
                  acc_in = int_sum;
               end
            end else if (frac_pos_ff <= FP_W'(FRAC_DIGITS)) begin
               acc_in      = frac_sum;
               frac_pos_in = frac_pos_ff + 1'b1;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         point_ff    <= 1'b0;
         frac_pos_ff <= FP_W'(1);
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         point_ff    <= point_in;
         frac_pos_ff <= frac_pos_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
      end
   end

   assign value    = neg_ff ? -acc_ff : acc_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire
